@@ rtl/ttdb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttdb_pkg: shared definitions for the tick timer and task delay bank
// Operation codes, field widths, stream packing widths and the
// default bank sizes.
// ----------------------------------------------------------------------------
package ttdb_pkg;

    // field widths
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 3;
    localparam int AMOUNT_W = 32;
    localparam int MASK_W   = 8;
    localparam int TIME_W   = 32;

    // stream packing, padded to whole bytes
    localparam int IN_TDATA_W  = 40;   // slot, amount, periodic, pad
    localparam int IN_TUSER_W  = OP_W; // operation
    localparam int OUT_TDATA_W = 56;   // fired_mask, ready_mask, sleeping, time_now, pad

    // bit positions in the input tdata
    localparam int IN_SLOT_LO   = 0;
    localparam int IN_AMOUNT_LO = IN_SLOT_LO + SLOT_W;
    localparam int IN_PER_BIT   = IN_AMOUNT_LO + AMOUNT_W;

    // default bank sizes
    localparam int NUM_TIMERS_DEF = 8;
    localparam int NUM_TASKS_DEF  = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK         = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE_TASK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELAY_TASK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CREATE_TIMER = 3'd3;
    localparam logic [OP_W-1:0] OP_START_TIMER  = 3'd4;
    localparam logic [OP_W-1:0] OP_STOP_TIMER   = 3'd5;
    localparam logic [OP_W-1:0] OP_SET_SLEEP    = 3'd6;

endpackage : ttdb_pkg
`default_nettype wire

@@ rtl/tick_timer_and_task_delay_bank_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tick_timer_and_task_delay_bank_top: software timer and task delay bank
//
//   channel  | dir | tvalid/tready                    | payload
//   ---------+-----+----------------------------------+------------------------------
//   command  | in  | i_s_axis_tvalid, o_s_axis_tready | tuser: operation
//            |     |                                  | tdata: slot, amount, periodic
//   status   | out | o_m_axis_tvalid, i_m_axis_tready | tdata: fired, ready, sleep, time
//
// One request per cycle while the status is taken: a request is captured in
// an input register, then updates the bank state and the status word when the
// output register is free or being taken; the status sits there until taken.
// Reset is synchronous, active low, and clears the valid flags, the registered
// and enabled slot flags, the sleep count and the time. A stalled status output
// holds the input register, which then stops taking requests once it is full.
// ----------------------------------------------------------------------------
module tick_timer_and_task_delay_bank_top #(
    parameter int NUM_TIMERS = ttdb_pkg::NUM_TIMERS_DEF,
    parameter int NUM_TASKS  = ttdb_pkg::NUM_TASKS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // command request
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [2:0] slot, [34:3] amount, [35] periodic, [39:36] zero
    input  wire logic [ttdb_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // [2:0] operation
    input  wire logic [ttdb_pkg::IN_TUSER_W-1:0] i_s_axis_tuser,
    // status request
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [7:0] fired_mask, [15:8] ready_mask, [16] sleeping, [48:17] time_now,
    // [55:49] zero
    output logic [ttdb_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import ttdb_pkg::*;

    // input register
    logic                r_in_valid;
    logic [OP_W-1:0]     r_op;
    logic [SLOT_W-1:0]   r_slot;
    logic [AMOUNT_W-1:0] r_amount;
    logic                r_per;

    // bank state
    logic [NUM_TASKS-1:0]  r_task_reg;
    logic [AMOUNT_W-1:0]   r_task_delay [NUM_TASKS];
    logic [NUM_TIMERS-1:0] r_tmr_reg;
    logic [NUM_TIMERS-1:0] r_tmr_en;
    logic [NUM_TIMERS-1:0] r_tmr_per;
    logic [AMOUNT_W-1:0]   r_tmr_period  [NUM_TIMERS];
    logic [AMOUNT_W-1:0]   r_tmr_elapsed [NUM_TIMERS];
    logic [AMOUNT_W-1:0]   r_sleep;
    logic [TIME_W-1:0]     r_time;

    // next state
    logic [NUM_TASKS-1:0]  n_task_reg;
    logic [AMOUNT_W-1:0]   n_task_delay [NUM_TASKS];
    logic [NUM_TIMERS-1:0] n_tmr_reg;
    logic [NUM_TIMERS-1:0] n_tmr_en;
    logic [NUM_TIMERS-1:0] n_tmr_per;
    logic [AMOUNT_W-1:0]   n_tmr_period  [NUM_TIMERS];
    logic [AMOUNT_W-1:0]   n_tmr_elapsed [NUM_TIMERS];
    logic [AMOUNT_W-1:0]   n_sleep;
    logic [TIME_W-1:0]     n_time;

    // output register
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_fired;
    logic [MASK_W-1:0] r_out_ready;
    logic              r_out_sleep;
    logic [TIME_W-1:0] r_out_time;

    logic                  w_adv;
    logic [NUM_TIMERS-1:0] w_fire;
    logic [MASK_W-1:0]     w_fired_mask;
    logic [MASK_W-1:0]     w_ready_mask;
    logic [AMOUNT_W-1:0]   w_delay_sel;
    logic [AMOUNT_W:0]     w_delay_sum;
    logic [AMOUNT_W-1:0]   w_delay_add;
    logic                  w_is_tick;

    // handshake: move the request on when the output register is free
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_is_tick       = (r_op == OP_TICK);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_op     <= i_s_axis_tuser;
            r_slot   <= i_s_axis_tdata[IN_SLOT_LO +: SLOT_W];
            r_amount <= i_s_axis_tdata[IN_AMOUNT_LO +: AMOUNT_W];
            r_per    <= i_s_axis_tdata[IN_PER_BIT];
        end
    end

    // saturating add of the addressed task delay
    always_comb begin
        w_delay_sel = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (int'(r_slot) == i) begin
                w_delay_sel = r_task_delay[i];
            end
        end
    end

    assign w_delay_sum = {1'b0, w_delay_sel} + {1'b0, r_amount};
    assign w_delay_add = w_delay_sum[AMOUNT_W] ? '1 : w_delay_sum[AMOUNT_W-1:0];

    // sleep count and free-running time
    always_comb begin
        n_sleep = r_sleep;
        n_time  = r_time;
        if (w_is_tick) begin
            n_time = r_time + 1'b1;
            if (r_sleep != '0) begin
                n_sleep = r_sleep - 1'b1;
            end
        end else if (r_op == OP_SET_SLEEP) begin
            n_sleep = r_amount;
        end
    end

    // task slots
    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            n_task_reg[i]   = r_task_reg[i];
            n_task_delay[i] = r_task_delay[i];
            unique case (r_op)
                OP_TICK: begin
                    if (r_task_reg[i] && r_task_delay[i] != '0) begin
                        n_task_delay[i] = r_task_delay[i] - 1'b1;
                    end
                end
                OP_CREATE_TASK: begin
                    if (int'(r_slot) == i) begin
                        n_task_reg[i]   = 1'b1;
                        n_task_delay[i] = '0;
                    end
                end
                OP_DELAY_TASK: begin
                    if (int'(r_slot) == i && r_task_reg[i]) begin
                        n_task_delay[i] = w_delay_add;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // timer slots
    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            n_tmr_reg[i]     = r_tmr_reg[i];
            n_tmr_en[i]      = r_tmr_en[i];
            n_tmr_per[i]     = r_tmr_per[i];
            n_tmr_period[i]  = r_tmr_period[i];
            n_tmr_elapsed[i] = r_tmr_elapsed[i];
            w_fire[i]        = 1'b0;
            unique case (r_op)
                OP_TICK: begin
                    if (r_tmr_reg[i] && r_tmr_en[i]) begin
                        if (r_tmr_elapsed[i] >= r_tmr_period[i]) begin
                            w_fire[i] = 1'b1;
                            if (r_tmr_per[i]) begin
                                n_tmr_elapsed[i] = '0;
                            end else begin
                                n_tmr_en[i] = 1'b0;
                            end
                        end else begin
                            n_tmr_elapsed[i] = r_tmr_elapsed[i] + 1'b1;
                        end
                    end
                end
                OP_CREATE_TIMER: begin
                    if (int'(r_slot) == i && !r_tmr_reg[i]) begin
                        n_tmr_reg[i]     = 1'b1;
                        n_tmr_elapsed[i] = '0;
                        n_tmr_per[i]     = r_per;
                        n_tmr_period[i]  = r_amount;
                    end
                end
                OP_START_TIMER, OP_STOP_TIMER: begin
                    if (int'(r_slot) == i && r_tmr_reg[i]) begin
                        n_tmr_en[i]      = (r_op == OP_START_TIMER);
                        n_tmr_elapsed[i] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // status masks, only the low slots are reported
    for (genvar j = 0; j < MASK_W; j++) begin : g_mask
        if (j < NUM_TIMERS) begin : g_fire
            assign w_fired_mask[j] = w_fire[j];
        end else begin : g_no_fire
            assign w_fired_mask[j] = 1'b0;
        end
        if (j < NUM_TASKS) begin : g_rdy
            assign w_ready_mask[j] = n_task_reg[j] && (n_task_delay[j] == '0);
        end else begin : g_no_rdy
            assign w_ready_mask[j] = 1'b0;
        end
    end

    // bank flags and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_reg <= '0;
            r_tmr_reg  <= '0;
            r_tmr_en   <= '0;
            r_sleep    <= '0;
            r_time     <= '0;
        end else if (w_adv) begin
            r_task_reg <= n_task_reg;
            r_tmr_reg  <= n_tmr_reg;
            r_tmr_en   <= n_tmr_en;
            r_sleep    <= n_sleep;
            r_time     <= n_time;
        end
    end

    // slot payload, always written on create before first use
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tmr_per <= n_tmr_per;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_task_delay[i] <= n_task_delay[i];
            end
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_tmr_period[i]  <= n_tmr_period[i];
                r_tmr_elapsed[i] <= n_tmr_elapsed[i];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_fired <= w_fired_mask;
            r_out_ready <= w_ready_mask;
            r_out_sleep <= (n_sleep != '0);
            r_out_time  <= n_time;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 2*MASK_W - 1 - TIME_W){1'b0}},
                              r_out_time, r_out_sleep, r_out_ready, r_out_fired};

    // checks
    a_fire_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_is_tick) |=> (r_out_fired == '0))
        else $error("timer fired on a command request");

    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_tick) |=> (r_time == $past(r_time) + 1'b1))
        else $error("time did not advance on a tick");

    a_time_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_is_tick) |=> $stable(r_time))
        else $error("time moved on a command request");

    a_en_needs_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_tmr_en & ~r_tmr_reg) == '0))
        else $error("enabled timer slot is not registered");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_amount) && $stable(r_op)))
        else $error("held request was overwritten");

endmodule : tick_timer_and_task_delay_bank_top
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tick timer and task delay bank
// Drives command requests into the stream input, keeps its own copy of the
// task and timer bank to predict each status word, and compares every
// status request field by field. A directed part covers the corner cases,
// then random traffic runs under changing idle patterns and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import ttdb_pkg::*;

    localparam int              BANK_SLOTS     = 8;
    localparam int              WATCHDOG_LIMIT = 2000;
    localparam int              SETTLE_CYCLES  = 8;
    localparam logic [OP_W-1:0] OP_UNUSED      = 3'd7;

    typedef struct {
        logic [MASK_W-1:0] fired;
        logic [MASK_W-1:0] ready;
        logic              sleeping;
        logic [TIME_W-1:0] time_now;
    } t_status;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [2:0] slot, [34:3] amount, [35] periodic, [39:36] zero
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // [2:0] operation
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [7:0] fired_mask, [15:8] ready_mask, [16] sleeping, [48:17] time_now,
    // [55:49] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // shadow copy of the bank
    logic                task_used    [BANK_SLOTS];
    logic [AMOUNT_W-1:0] task_wait    [BANK_SLOTS];
    logic                timer_used   [BANK_SLOTS];
    logic                timer_run    [BANK_SLOTS];
    logic                timer_repeat [BANK_SLOTS];
    logic [AMOUNT_W-1:0] timer_limit  [BANK_SLOTS];
    logic [AMOUNT_W-1:0] timer_ticks  [BANK_SLOTS];
    logic [AMOUNT_W-1:0] sleep_left = '0;
    logic [TIME_W-1:0]   tick_count = '0;

    t_status status_q[$];
    int      error_count      = 0;
    int      idle_cycles      = 0;
    int      send_idle_pct    = 0;
    int      recv_idle_pct    = 0;
    int      recv_hold_cycles = 0;

    tick_timer_and_task_delay_bank_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < BANK_SLOTS; i++) begin
            task_used[i]    = 1'b0;
            task_wait[i]    = '0;
            timer_used[i]   = 1'b0;
            timer_run[i]    = 1'b0;
            timer_repeat[i] = 1'b0;
            timer_limit[i]  = '0;
            timer_ticks[i]  = '0;
        end
    end

    // apply one command to the shadow bank and return the status it reports
    function automatic t_status advance_bank(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                             logic [AMOUNT_W-1:0] amount, logic per);
        t_status     st;
        logic [32:0] sum;
        st.fired = '0;
        st.ready = '0;
        case (op)
            OP_TICK: begin
                if (sleep_left != 0) sleep_left = sleep_left - 1;
                for (int i = 0; i < BANK_SLOTS; i++)
                    if (task_used[i] && task_wait[i] != 0) task_wait[i] = task_wait[i] - 1;
                for (int i = 0; i < BANK_SLOTS; i++) begin
                    if (timer_used[i] && timer_run[i]) begin
                        if (timer_ticks[i] >= timer_limit[i]) begin
                            st.fired[i] = 1'b1;
                            if (timer_repeat[i]) timer_ticks[i] = '0;
                            else timer_run[i] = 1'b0;
                        end else begin
                            timer_ticks[i] = timer_ticks[i] + 1;
                        end
                    end
                end
                tick_count = tick_count + 1;
            end
            OP_CREATE_TASK: begin
                task_used[slot] = 1'b1;
                task_wait[slot] = '0;
            end
            OP_DELAY_TASK: begin
                if (task_used[slot]) begin
                    sum = {1'b0, task_wait[slot]} + {1'b0, amount};
                    task_wait[slot] = sum[32] ? '1 : sum[31:0];
                end
            end
            OP_CREATE_TIMER: begin
                if (!timer_used[slot]) begin
                    timer_used[slot]   = 1'b1;
                    timer_ticks[slot]  = '0;
                    timer_repeat[slot] = per;
                    timer_limit[slot]  = amount;
                end
            end
            OP_START_TIMER, OP_STOP_TIMER: begin
                if (timer_used[slot]) begin
                    timer_run[slot]   = (op == OP_START_TIMER);
                    timer_ticks[slot] = '0;
                end
            end
            OP_SET_SLEEP: sleep_left = amount;
            default: ;
        endcase
        for (int i = 0; i < BANK_SLOTS; i++)
            st.ready[i] = task_used[i] && task_wait[i] == 0;
        st.sleeping = (sleep_left != 0);
        st.time_now = tick_count;
        return st;
    endfunction

    // offer one command request, with random gaps ahead of it
    task automatic send_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                logic [AMOUNT_W-1:0] amount, logic per);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'b0, per, amount, slot};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        status_q.push_back(advance_bank(op, slot, amount, per));
    endtask

    // amounts mostly small so timers fire and delays run out
    function automatic logic [AMOUNT_W-1:0] pick_amount();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(6);
        if (roll < 90) return $urandom_range(40);
        return $urandom;
    endfunction

    task automatic send_random_command();
        int              roll;
        logic [OP_W-1:0] op;
        roll = $urandom_range(99);
        if (roll < 40)      op = OP_TICK;
        else if (roll < 48) op = OP_CREATE_TASK;
        else if (roll < 62) op = OP_DELAY_TASK;
        else if (roll < 70) op = OP_CREATE_TIMER;
        else if (roll < 82) op = OP_START_TIMER;
        else if (roll < 89) op = OP_STOP_TIMER;
        else if (roll < 97) op = OP_SET_SLEEP;
        else                op = OP_UNUSED;
        send_command(op, SLOT_W'($urandom_range(BANK_SLOTS - 1)), pick_amount(),
                     1'($urandom_range(1)));
    endtask

    // stop offering and wait for every outstanding status
    task automatic drain_status();
        i_s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_commands();
        send_command(OP_UNUSED, 3'd7, '1, 1'b1);
        send_command(OP_TICK, 3'd0, '0, 1'b0);
        // commands to unregistered slots are dropped
        send_command(OP_DELAY_TASK, 3'd2, 32'd5, 1'b0);
        send_command(OP_START_TIMER, 3'd3, '0, 1'b0);
        send_command(OP_CREATE_TASK, 3'd0, '0, 1'b0);
        send_command(OP_CREATE_TASK, 3'd7, '1, 1'b1);
        // delay saturates at the top
        send_command(OP_DELAY_TASK, 3'd7, '1, 1'b0);
        send_command(OP_DELAY_TASK, 3'd7, 32'd1, 1'b1);
        send_command(OP_DELAY_TASK, 3'd0, 32'd2, 1'b0);
        // zero period periodic, then a create on a taken slot
        send_command(OP_CREATE_TIMER, 3'd0, '0, 1'b1);
        send_command(OP_CREATE_TIMER, 3'd0, 32'd5, 1'b0);
        send_command(OP_CREATE_TIMER, 3'd7, 32'd1, 1'b0);
        send_command(OP_START_TIMER, 3'd0, '1, 1'b0);
        send_command(OP_START_TIMER, 3'd7, '0, 1'b1);
        send_command(OP_SET_SLEEP, 3'd5, 32'd2, 1'b0);
        repeat (4) send_command(OP_TICK, 3'd0, '0, 1'b0);
        // re-create clears a saturated delay
        send_command(OP_CREATE_TASK, 3'd7, '0, 1'b0);
        send_command(OP_STOP_TIMER, 3'd0, '0, 1'b0);
        send_command(OP_TICK, 3'd0, '1, 1'b1);
        send_command(OP_SET_SLEEP, 3'd1, '1, 1'b1);
        send_command(OP_SET_SLEEP, 3'd1, '0, 1'b0);
    endtask

    task automatic run_random_traffic(int count);
        repeat (count) send_random_command();
    endtask

    task automatic test_slow_receiver();
        send_idle_pct = 7;
        recv_idle_pct = 51;
        run_random_traffic(330);
    endtask

    task automatic test_slow_sender();
        send_idle_pct = 51;
        recv_idle_pct = 7;
        run_random_traffic(330);
    endtask

    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(300);
    endtask

    // status output held off while requests keep coming
    task automatic test_output_backpressure();
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = 60;
        run_random_traffic(25);
    endtask

    // sender goes quiet until the bank has answered everything
    task automatic test_sender_pause();
        drain_status();
        run_random_traffic(10);
    endtask

    // status receiver with random stalls and long hold-offs
    always @(posedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            i_m_axis_tready  <= 1'b0;
            recv_hold_cycles = recv_hold_cycles - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // compare each status request with the oldest prediction
    always @(posedge i_clk) begin : check_status
        t_status want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (status_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected status, expected none, actual %0h",
                         $time, o_m_axis_tdata);
            end else begin
                want = status_q.pop_front();
                report_field("fired_mask", TIME_W'(want.fired),
                             TIME_W'(o_m_axis_tdata[7:0]));
                report_field("ready_mask", TIME_W'(want.ready),
                             TIME_W'(o_m_axis_tdata[15:8]));
                report_field("sleeping", TIME_W'(want.sleeping),
                             TIME_W'(o_m_axis_tdata[16]));
                report_field("time_now", want.time_now, o_m_axis_tdata[48:17]);
                report_field("pad", '0, TIME_W'(o_m_axis_tdata[55:49]));
            end
        end
    end

    // end the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_commands();
        test_slow_receiver();
        test_slow_sender();
        test_sender_pause();
        test_output_backpressure();
        test_full_rate();
        drain_status();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && status_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule : tb_top
`default_nettype wire
